[rtl/rsc_pkg.sv]
// shared constants and codes for the resizing stack
package rsc_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int DATA_W_DEF = 32;
  localparam int CFG_W      = 11;
  localparam int CAP_RESET  = 10;

  localparam logic [CFG_W-1:0] MIN_CAP_RESET = CFG_W'(CAP_RESET);

  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_PEEK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one capacity check request to the policy unit
  typedef struct packed {
    logic check;
    logic is_push;
  } chk_req_t;

endpackage

[rtl/rsc_mem.sv]
// element store: one write port, one registered read port
module rsc_mem
  import rsc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = DATA_W_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/rsc_policy.sv]
// logical capacity policy: grow, shrink, resize count and peak
module rsc_policy
  import rsc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  chk_req_t                   req,
  input  logic [$clog2(DEPTH+1)-1:0] fill,
  input  logic [CFG_W-1:0]           min_cap,
  output logic [$clog2(DEPTH+1)-1:0] cap,
  output logic [31:0]                total,
  output logic [$clog2(DEPTH+1)-1:0] peak
);

  localparam int CW = $clog2(DEPTH+1);

  logic [CW-1:0] level;
  logic [CW-1:0] lo;
  logic [CW-1:0] half;
  logic [CW:0]   grown_raw;
  logic [CW-1:0] grown;
  logic          do_grow;
  logic          do_shrink;
  logic [CW-1:0] cap_next;
  logic [CW-1:0] peak_next;
  logic [31:0]   total_next;

  always_comb begin
    // a push checks against the count after storing, a pop before removing
    level = req.is_push ? fill + CW'(1) : fill;

    if (min_cap == '0) begin
      lo = CW'(1);
    end else if (32'(min_cap) > 32'(DEPTH)) begin
      lo = CW'(DEPTH);
    end else begin
      lo = CW'(min_cap);
    end

    half      = cap >> 1;
    grown_raw = {1'b0, cap} + {1'b0, half};
    grown     = (grown_raw > (CW+1)'(DEPTH)) ? CW'(DEPTH) : grown_raw[CW-1:0];

    do_grow   = 1'b0;
    do_shrink = 1'b0;
    if (req.check) begin
      if (level >= cap) begin
        do_grow = (grown != cap);
      end else begin
        do_shrink = (level != '0) && ((level - CW'(1)) < half) && (cap > lo);
      end
    end

    cap_next   = cap;
    peak_next  = peak;
    total_next = total;
    if (do_grow) begin
      cap_next  = grown;
      peak_next = (grown > peak) ? grown : peak;
    end else if (do_shrink) begin
      cap_next = (half < lo) ? lo : half;
    end
    if ((do_grow || do_shrink) && (total != '1)) begin
      total_next = total + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CW'(CAP_RESET);
      peak  <= CW'(CAP_RESET);
      total <= '0;
    end else begin
      cap   <= cap_next;
      peak  <= peak_next;
      total <= total_next;
    end
  end

endmodule

[rtl/resizing_stack_with_capacity_policy.sv]
// resizing stack top level: command decode, fill pointer and result strobe
//
//   channel   handshake              payload
//   command   start / busy           func, push_value
//   result    done (one cycle)       read_value, status, occupancy, capacity_now,
//                                    resize_total, peak_capacity
//   config    cfg_valid / cfg_ready  cfg_data (min_capacity)
//
// one request per cycle; the result strobe comes in the cycle after the request is taken,
// as does the read data from the single read port of the element store, which is registered.
// busy stays low, a new request may be taken in the cycle that shows done.
// rst is synchronous: stack empty, capacity and peak ten, resize count zero,
// min_capacity ten. the store holds no reset value and needs no clearing.
// the receiver cannot stall: each result shows once, for exactly one cycle.
module resizing_stack_with_capacity_policy
  import rsc_pkg::*;
#(
  parameter int STORE_DEPTH = DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic signed [DATA_WIDTH-1:0]     push_value,
  output logic                             done,
  output logic signed [DATA_WIDTH-1:0]     read_value,
  output logic [1:0]                       status,
  output logic [$clog2(STORE_DEPTH+1)-1:0] occupancy,
  output logic [$clog2(STORE_DEPTH+1)-1:0] capacity_now,
  output logic [31:0]                      resize_total,
  output logic [$clog2(STORE_DEPTH+1)-1:0] peak_capacity,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_W-1:0]                 cfg_data
);

  localparam int CW = $clog2(STORE_DEPTH+1);
  localparam int AW = $clog2(STORE_DEPTH);

  logic [CFG_W-1:0]      min_cap;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  wr_en;
  logic                  rd_en;
  logic                  is_pop;
  logic [CW-1:0]         top_idx;
  status_t               status_d;
  status_t               status_q;
  logic                  rv_sel;
  logic [DATA_WIDTH-1:0] rd_data;
  chk_req_t              req;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (32'(fill) >= 32'(STORE_DEPTH));
  assign empty     = (fill == '0);
  assign top_idx   = fill - CW'(1);

  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    is_pop   = 1'b0;
    status_d = ST_OK;
    unique case (func_t'(func))
      FN_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          wr_en = accept;
        end
      end
      FN_POP: begin
        is_pop = 1'b1;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en = accept;
        end
      end
      default: begin
        // peek, and the unused code acts as a peek
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en = accept;
        end
      end
    endcase

    req.check   = wr_en || (rd_en && is_pop);
    req.is_push = wr_en;

    fill_next = fill;
    if (wr_en) begin
      fill_next = fill + CW'(1);
    end else if (rd_en && is_pop) begin
      fill_next = top_idx;
    end
  end

  rsc_mem #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[AW-1:0]),
    .wr_data (push_value),
    .rd_en   (rd_en),
    .rd_addr (top_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  rsc_policy #(
    .DEPTH (STORE_DEPTH)
  ) u_policy (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .fill    (fill),
    .min_cap (min_cap),
    .cap     (capacity_now),
    .total   (resize_total),
    .peak    (peak_capacity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cap  <= MIN_CAP_RESET;
      fill     <= '0;
      done     <= 1'b0;
      status_q <= ST_OK;
      rv_sel   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_cap <= cfg_data;
      end
      fill <= fill_next;
      done <= accept;
      if (accept) begin
        status_q <= status_d;
        rv_sel   <= rd_en;
      end
    end
  end

  assign read_value = rv_sel ? rd_data : '0;
  assign status     = status_q;
  assign occupancy  = fill;

endmodule

[tb/tb_resizing_stack_with_capacity_policy.sv]
// testbench for the resizing stack: directed table, then random push/pop/peek against a predictor
`timescale 1ns / 100ps

module tb_resizing_stack_with_capacity_policy;
  import rsc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [31:0] rd;
    status_t     st;
    logic [10:0] occ;
    logic [10:0] cap;
    logic [31:0] tot;
    logic [10:0] peak;
  } stack_result_t;

  typedef struct packed {
    logic [1:0]    fn;
    logic [31:0]   val;
    bit            typed;
    stack_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = FN_PUSH;
  logic [31:0] push_value = '0;
  logic        cfg_valid = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        busy, done, cfg_ready;
  logic [31:0] read_value, resize_total;
  logic [1:0]  status;
  logic [10:0] occupancy, capacity_now, peak_capacity;

  resizing_stack_with_capacity_policy dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .push_value(push_value), .done(done), .read_value(read_value), .status(status),
    .occupancy(occupancy), .capacity_now(capacity_now), .resize_total(resize_total),
    .peak_capacity(peak_capacity), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the stack and its capacity policy
  logic [31:0]   shadow_mem [DEPTH];
  int            shadow_fill = 0;
  int            shadow_cap = CAP_RESET;
  int            shadow_peak = CAP_RESET;
  logic [31:0]   shadow_resizes = '0;
  logic [10:0]   shadow_floor = MIN_CAP_RESET;
  stack_result_t pending_results [$];

  int requests_sent = 0, results_checked = 0, errors = 0, shown = 0;
  int n_grow = 0, n_shrink = 0, n_flat_grow = 0, n_empty = 0, n_full = 0;

  function automatic void capacity_policy();
    int lo;
    int g;
    lo = (shadow_floor == 0) ? 1 : ((shadow_floor > DEPTH) ? DEPTH : int'(shadow_floor));
    if (shadow_fill >= shadow_cap) begin
      g = shadow_cap + shadow_cap / 2;
      if (g > DEPTH) g = DEPTH;
      if (g != shadow_cap) begin
        shadow_cap = g;
        if (shadow_resizes != 32'hFFFF_FFFF) shadow_resizes++;
        if (g > shadow_peak) shadow_peak = g;
        n_grow++;
      end else begin
        n_flat_grow++;
      end
    end else if (shadow_fill >= 1 && (shadow_fill - 1) < shadow_cap / 2 && shadow_cap > lo) begin
      g = shadow_cap / 2;
      if (g < lo) g = lo;
      shadow_cap = g;
      if (shadow_resizes != 32'hFFFF_FFFF) shadow_resizes++;
      n_shrink++;
    end
  endfunction

  function automatic stack_result_t predict_stack_op(logic [1:0] fn, logic [31:0] val);
    stack_result_t r;
    r.rd = '0;
    r.st = ST_OK;
    if (fn == FN_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        r.st = ST_FULL;
        n_full++;
      end else begin
        shadow_mem[shadow_fill] = val;
        shadow_fill++;
        capacity_policy();
      end
    end else if (shadow_fill == 0) begin
      r.st = ST_EMPTY;
      n_empty++;
    end else if (fn == FN_POP) begin
      capacity_policy();
      r.rd = shadow_mem[shadow_fill - 1];
      shadow_fill--;
    end else begin
      // peek, and the unused code that behaves like one
      r.rd = shadow_mem[shadow_fill - 1];
    end
    r.occ  = 11'(shadow_fill);
    r.cap  = 11'(shadow_cap);
    r.tot  = shadow_resizes;
    r.peak = 11'(shadow_peak);
    return r;
  endfunction

  // start stays high across back-to-back requests, lowered only by pauses and drains
  task automatic issue(input logic [1:0] fn, input logic [31:0] val, input bit typed,
                       input stack_result_t want);
    stack_result_t guess;
    start <= 1'b1;
    func <= fn;
    push_value <= val;
    do @(posedge clk); while (busy);
    guess = predict_stack_op(fn, val);
    pending_results.push_back(typed ? want : guess);
    requests_sent++;
  endtask

  task automatic pause_maybe(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_floor(input logic [10:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_floor = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic table_row_t row(logic [1:0] fn, logic [31:0] val, bit typed,
                                     logic [31:0] rd, status_t st, int occ, int cap,
                                     int tot, int peak);
    table_row_t t;
    t.fn = fn;
    t.val = val;
    t.typed = typed;
    t.want.rd = rd;
    t.want.st = st;
    t.want.occ = 11'(occ);
    t.want.cap = 11'(cap);
    t.want.tot = 32'(tot);
    t.want.peak = 11'(peak);
    return t;
  endfunction

  // result checker: the block cannot stall results, so every done is consumed here
  always @(posedge clk) begin
    stack_result_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: rd=%h st=%0d occ=%0d", read_value, status, occupancy);
        end
      end else begin
        w = pending_results.pop_front();
        results_checked++;
        if (read_value !== w.rd || status !== w.st || occupancy !== w.occ ||
            capacity_now !== w.cap || resize_total !== w.tot || peak_capacity !== w.peak) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch at result %0d: expected rd=%h st=%0d occ=%0d cap=%0d tot=%0d pk=%0d",
                     results_checked, w.rd, w.st, w.occ, w.cap, w.tot, w.peak);
            $display("                      got      rd=%h st=%0d occ=%0d cap=%0d tot=%0d pk=%0d",
                     read_value, status, occupancy, capacity_now, resize_total, peak_capacity);
          end
        end
      end
    end
  end

  initial begin
    table_row_t    dir_tab [$];
    stack_result_t none;
    logic [10:0]   floors [6];
    int            pcts [4];
    int            bias, push_lim, r, pct;
    logic [1:0]    fn;
    logic [31:0]   val;
    logic [31:0]   edge_vals [4];

    none = '0;
    edge_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    // floor of 2047 acts as the full depth, 0 acts as 1
    floors = '{11'd2047, 11'($urandom_range(2, 40)), 11'd1024, 11'd0, 11'd1,
               11'($urandom_range(2, 40))};
    pcts = '{0, 67, 0, 29};

    // after reset: empty accesses, extremes of the value, unused func code
    dir_tab.push_back(row(FN_PEEK, 32'h0, 1, 32'h0, ST_EMPTY, 0, 10, 0, 10));
    dir_tab.push_back(row(FN_POP, 32'h0, 1, 32'h0, ST_EMPTY, 0, 10, 0, 10));
    dir_tab.push_back(row(2'd3, 32'h0, 1, 32'h0, ST_EMPTY, 0, 10, 0, 10));
    dir_tab.push_back(row(FN_PUSH, 32'h7FFF_FFFF, 1, 32'h0, ST_OK, 1, 10, 0, 10));
    dir_tab.push_back(row(FN_PUSH, 32'h8000_0000, 1, 32'h0, ST_OK, 2, 10, 0, 10));
    dir_tab.push_back(row(FN_PEEK, 32'h0, 1, 32'h8000_0000, ST_OK, 2, 10, 0, 10));
    dir_tab.push_back(row(2'd3, 32'h0, 1, 32'h8000_0000, ST_OK, 2, 10, 0, 10));
    dir_tab.push_back(row(FN_POP, 32'h0, 1, 32'h8000_0000, ST_OK, 1, 10, 0, 10));
    dir_tab.push_back(row(FN_POP, 32'h0, 1, 32'h7FFF_FFFF, ST_OK, 0, 10, 0, 10));
    // ten pushes grow the capacity, then a few pops start to empty the stack
    for (int i = 0; i < 10; i++)
      dir_tab.push_back(row(FN_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'h5555_0000 + i, 0,
                            0, ST_OK, 0, 0, 0, 0));
    dir_tab.push_back(row(FN_PEEK, 32'h0, 0, 0, ST_OK, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(row(FN_POP, 32'h0, 0, 0, ST_OK, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_floor(MIN_CAP_RESET);

    foreach (dir_tab[i]) begin
      pause_maybe(30);
      issue(dir_tab[i].fn, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      pct = pcts[ph % 4];
      write_floor(floors[ph]);
      bias = 0;
      for (int n = 0; n < 71; n++) begin
        if (n % 20 == 0) bias = $urandom_range(2);
        pause_maybe(pct);
        if ($urandom_range(59) == 0) drain();
        push_lim = (bias == 0) ? 70 : ((bias == 1) ? 30 : 50);
        r = $urandom_range(99);
        if (r < push_lim) begin
          fn = FN_PUSH;
        end else begin
          r = $urandom_range(9);
          fn = (r < 6) ? FN_POP : ((r < 9) ? FN_PEEK : 2'd3);
        end
        val = ($urandom_range(7) == 0) ? edge_vals[$urandom_range(3)] : $urandom;
        issue(fn, val, 0, none);
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    $display("covered %0d requests, %0d results checked, %0d mismatches",
             requests_sent, results_checked, errors);
    $display("grows %0d, shrinks %0d, grows without effect %0d, empty %0d, refused pushes %0d",
             n_grow, n_shrink, n_flat_grow, n_empty, n_full);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule
